FILE: rtl/core/wbrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbrm_pkg
// Shared types and constants of the windowed busy ratio meter.
// ----------------------------------------------------------------------------
package wbrm_pkg;

  localparam int unsigned REQ_W   = 2;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned LOAD_W  = 7;
  localparam int unsigned WSIZE_W = 7;

  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd16;
  localparam logic [LOAD_W-1:0]  PCT_MAX     = 7'd100;

  typedef enum logic [REQ_W-1:0] {
    REQ_SLEEP = 2'd0,
    REQ_WORK  = 2'd1,
    REQ_QUERY = 2'd2
  } req_e;

  typedef struct packed {
    logic capture;
    logic evict;
    logic record;
    logic q_sum;
    logic q_tot;
    logic q_mul;
    logic div_step;
    logic out_load;
  } wbrm_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             need_evict;
    logic             zero_result;
  } wbrm_sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/wbrm_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbrm_req_if
// Request channel: request type and time stamp.
// ----------------------------------------------------------------------------
interface wbrm_req_if
  import wbrm_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [STAMP_W-1:0] now_usec;

  modport source (output valid, output req_type, output now_usec, input ready);
  modport sink   (input valid, input req_type, input now_usec, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/wbrm_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbrm_rsp_if
// Result channel: load in percent.
// ----------------------------------------------------------------------------
interface wbrm_rsp_if
  import wbrm_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [LOAD_W-1:0] load_percent;

  modport source (output valid, output load_percent, input ready);
  modport sink   (input valid, input load_percent, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/wbrm_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbrm_cfg_if
// Configuration write channel for the window size register.
// ----------------------------------------------------------------------------
interface wbrm_cfg_if
  import wbrm_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [WSIZE_W-1:0] window_size;

  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/wbrm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbrm_ctrl
// Sequencer for recording intervals and answering load queries.
// ----------------------------------------------------------------------------
module wbrm_ctrl
  import wbrm_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire wbrm_sts_t sts_i,
  output wbrm_cmd_t      cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_EVICT  = 9'b000000100,
    S_RECORD = 9'b000001000,
    S_QSUM   = 9'b000010000,
    S_QTOT   = 9'b000100000,
    S_QMUL   = 9'b001000000,
    S_DIV    = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.req)
          REQ_SLEEP, REQ_WORK: state_d = sts_i.need_evict ? S_EVICT : S_RECORD;
          REQ_QUERY:           state_d = S_QSUM;
          default:             state_d = S_IDLE;
        endcase
      end
      S_EVICT: begin
        cmd_o.evict = 1'b1;
        state_d     = S_RECORD;
      end
      S_RECORD: begin
        cmd_o.record = 1'b1;
        state_d      = S_IDLE;
      end
      S_QSUM: begin
        cmd_o.q_sum = 1'b1;
        state_d     = S_QTOT;
      end
      S_QTOT: begin
        cmd_o.q_tot = 1'b1;
        state_d     = S_QMUL;
      end
      S_QMUL: begin
        cmd_o.q_mul = 1'b1;
        step_d      = 3'd6;
        state_d     = sts_i.zero_result ? S_FINISH : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q - 3'd1;
        if (step_q == 3'd0) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QMUL && !sts_i.zero_result) |-> ##8 (state_q == S_FINISH))
    else $error("divider did not finish after seven steps");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_o)
    else $error("result loaded without valid");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> !in_ready_o)
    else $error("accepted a new item while one is in flight");

endmodule
`default_nettype wire

FILE: rtl/core/wbrm_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbrm_dp
// Interval window memory, running sums, and the percent divider.
// ----------------------------------------------------------------------------
module wbrm_dp
  import wbrm_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 64,
  parameter int unsigned TIME_BITS    = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [REQ_W-1:0]   req_type_i,
  input  wire logic [STAMP_W-1:0] now_usec_i,
  input  wire logic               cfg_we_i,
  input  wire logic [WSIZE_W-1:0] cfg_window_size_i,
  input  wire wbrm_cmd_t          cmd_i,
  output wbrm_sts_t               sts_o,
  output logic [LOAD_W-1:0]       load_percent_o
);

  localparam int unsigned TW    = TIME_BITS;
  localparam int unsigned IDX_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > WSIZE_W) ? CNT_W : WSIZE_W;
  localparam int unsigned SUM_W = TW + IDX_W;
  localparam int unsigned ACC_W = SUM_W + 1;
  localparam int unsigned TOT_W = ACC_W + 1;
  localparam int unsigned NUM_W = TOT_W + LOAD_W;

  logic [TW-1:0] now_t;
  if (TW <= STAMP_W) begin : g_trunc
    assign now_t = now_usec_i[TW-1:0];
  end else begin : g_ext
    assign now_t = {{(TW - STAMP_W){1'b0}}, now_usec_i};
  end

  logic [TW-1:0]      interval_mem_q [WINDOW_DEPTH];
  logic               sleep_mem_q    [WINDOW_DEPTH];
  logic [TW-1:0]      rd_dur_q;
  logic               rd_sleep_q;

  logic [WSIZE_W-1:0] window_size_q;
  logic [IDX_W-1:0]   oldest_q;
  logic [CNT_W-1:0]   count_q;
  logic               asleep_q;
  logic [TW-1:0]      sleep_stamp_q, wake_stamp_q;
  logic [SUM_W-1:0]   sleep_sum_q, run_sum_q;

  logic [REQ_W-1:0]   req_q;
  logic [TW-1:0]      now_q;
  logic [ACC_W-1:0]   s_q, r_q;
  logic [NUM_W-1:0]   num_q, dsh_q;
  logic [LOAD_W-1:0]  q_q, load_q;

  logic [CMP_W-1:0]   ws_ext, eff_size;
  logic [TW-1:0]      dur_run, dur_sleep, dur_new;
  logic               new_is_sleep;
  logic [CNT_W:0]     slot_sum;
  logic [IDX_W-1:0]   slot;
  logic [TOT_W-1:0]   total;
  logic               div_ge;

  assign ws_ext   = CMP_W'(window_size_q);
  assign eff_size = (ws_ext == '0) ? CMP_W'(1) :
                    (ws_ext > CMP_W'(WINDOW_DEPTH)) ? CMP_W'(WINDOW_DEPTH) : ws_ext;

  assign dur_run      = now_q - wake_stamp_q;
  assign dur_sleep    = now_q - sleep_stamp_q;
  assign new_is_sleep = (req_q == REQ_WORK);
  assign dur_new      = new_is_sleep ? dur_sleep : dur_run;

  assign slot_sum = (CNT_W + 1)'(oldest_q) + (CNT_W + 1)'(count_q);
  assign slot     = (slot_sum >= (CNT_W + 1)'(WINDOW_DEPTH)) ?
                    IDX_W'(slot_sum - (CNT_W + 1)'(WINDOW_DEPTH)) : IDX_W'(slot_sum);

  assign total  = TOT_W'(s_q) + TOT_W'(r_q);
  assign div_ge = (num_q >= dsh_q);

  assign sts_o.req         = req_q;
  assign sts_o.need_evict  = (CMP_W'(count_q) >= eff_size);
  assign sts_o.zero_result = (count_q == '0) || (dsh_q == '0);
  assign load_percent_o    = load_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.record) begin
      interval_mem_q[slot] <= dur_new;
      sleep_mem_q[slot]    <= new_is_sleep;
    end
    rd_dur_q   <= interval_mem_q[oldest_q];
    rd_sleep_q <= sleep_mem_q[oldest_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WSIZE_RESET;
      oldest_q      <= '0;
      count_q       <= '0;
      asleep_q      <= 1'b0;
      sleep_stamp_q <= '0;
      wake_stamp_q  <= '0;
      sleep_sum_q   <= '0;
      run_sum_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        window_size_q <= cfg_window_size_i;
      end
      if (cmd_i.evict) begin
        oldest_q <= (oldest_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_q + IDX_W'(1);
        count_q  <= count_q - CNT_W'(1);
        if (rd_sleep_q) begin
          sleep_sum_q <= sleep_sum_q - SUM_W'(rd_dur_q);
        end else begin
          run_sum_q <= run_sum_q - SUM_W'(rd_dur_q);
        end
      end
      if (cmd_i.record) begin
        count_q  <= count_q + CNT_W'(1);
        asleep_q <= !new_is_sleep;
        if (new_is_sleep) begin
          wake_stamp_q <= now_q;
          sleep_sum_q  <= sleep_sum_q + SUM_W'(dur_new);
        end else begin
          sleep_stamp_q <= now_q;
          run_sum_q     <= run_sum_q + SUM_W'(dur_new);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_type_i;
      now_q <= now_t;
    end
    if (cmd_i.q_sum) begin
      s_q <= ACC_W'(sleep_sum_q) + (asleep_q ? ACC_W'(dur_sleep) : '0);
      r_q <= ACC_W'(run_sum_q) + (asleep_q ? '0 : ACC_W'(dur_run));
    end
    if (cmd_i.q_tot) begin
      dsh_q <= NUM_W'(total) << 6;
      num_q <= (NUM_W'(r_q) << 6) + (NUM_W'(r_q) << 5);
      q_q   <= '0;
    end
    if (cmd_i.q_mul) begin
      num_q <= num_q + (NUM_W'(r_q) << 2);
    end
    if (cmd_i.div_step) begin
      if (div_ge) begin
        num_q <= num_q - dsh_q;
      end
      dsh_q <= dsh_q >> 1;
      q_q   <= {q_q[LOAD_W-2:0], div_ge};
    end
    if (cmd_i.out_load) begin
      load_q <= q_q;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(WINDOW_DEPTH))
    else $error("entry count exceeds the window depth");

  a_record_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.record |=> (count_q != '0))
    else $error("window empty after a record");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (q_q <= PCT_MAX))
    else $error("load above one hundred percent");

endmodule
`default_nettype wire

FILE: rtl/core/windowed_busy_ratio_meter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_busy_ratio_meter_core
// Sliding window duty cycle meter over recorded sleep and run intervals.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A start-sleep or start-work item passes
// through the decode and record states before the block frees, with an
// evict state between them when the oldest record must first be evicted
// through the registered read port of the window memory. A query steps
// through the sum, total and multiply states and then the restoring divider
// that forms the percent quotient, and the block is ready again at the same
// edge that presents its result; a query on an empty window or with zero
// total time skips the divider. Unknown requests give no result and free the
// block after decode. A query whose result finds the previous one still
// waiting holds in its last state until the output register frees, and no
// new item is taken meanwhile. The window memory needs no clearing after
// reset. Write window_size only while the block is idle.
module windowed_busy_ratio_meter_core
  import wbrm_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 64,
  parameter int unsigned TIME_BITS    = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  wbrm_req_if.sink    in_ch,
  wbrm_rsp_if.source  out_ch,
  wbrm_cfg_if.sink    cfg_ch
);

  wbrm_cmd_t cmd;
  wbrm_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  wbrm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wbrm_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .TIME_BITS    (TIME_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_type_i        (in_ch.req_type),
    .now_usec_i        (in_ch.now_usec),
    .cfg_we_i          (cfg_ch.valid),
    .cfg_window_size_i (cfg_ch.window_size),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .load_percent_o    (out_ch.load_percent)
  );

endmodule
`default_nettype wire

FILE: verif/tb_windowed_busy_ratio_meter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_busy_ratio_meter_core
// Self-checking bench for the windowed busy ratio meter. A queue of sleep,
// work, query and unknown requests is fed through the request channel while
// a local predictor tracks the record window, the running sums and the
// window size register. Every load result is checked in order. The window
// size is reprogrammed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_windowed_busy_ratio_meter_core;
  import wbrm_pkg::*;

  localparam int unsigned SLOTS          = 64;
  localparam int unsigned IDLE_PCT       = 17;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned PHASE_ITEMS    = 100;
  localparam int          TIMEOUT_CYCLES = 400000;
  localparam int          QUIET_FROM     = 4000;
  localparam int          QUIET_TO       = 7000;

  localparam logic [REQ_W-1:0] REQ_BAD = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic [STAMP_W-1:0] stamp;
  } meter_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycle_count = 0;
  int   err_count = 0;
  logic quiet;
  logic req_fire = 1'b0;

  wbrm_req_if in_ch ();
  wbrm_rsp_if out_ch ();
  wbrm_cfg_if cfg_ch ();

  windowed_busy_ratio_meter_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  meter_item_t       send_queue [$];
  logic [LOAD_W-1:0] load_expected [$];
  meter_item_t       next_item;
  logic [LOAD_W-1:0] want_load;

  logic [STAMP_W-1:0] span_mem [SLOTS];
  logic               span_sleep [SLOTS];
  logic [5:0]         head_slot = '0;
  logic [6:0]         span_count = '0;
  logic               dozing = 1'b0;
  logic [STAMP_W-1:0] doze_stamp = '0;
  logic [STAMP_W-1:0] wake_stamp = '0;
  logic [63:0]        doze_total = '0;
  logic [63:0]        busy_total = '0;
  logic [WSIZE_W-1:0] size_reg = WSIZE_RESET;

  logic [STAMP_W-1:0] gen_clock = '0;
  logic               gen_asleep = 1'b0;
  logic [WSIZE_W-1:0] size_plan [10] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd2,
                                         7'd40, 7'd64, 7'd3, 7'd65, 7'd16};

  always #5 clk_i = ~clk_i;

  assign quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  task automatic log_interval(input logic [STAMP_W-1:0] dur, input logic is_sleep);
    int unsigned lim;
    logic [5:0]  slot;
    lim = (size_reg == 0) ? 1 : (size_reg > SLOTS) ? SLOTS : size_reg;
    if (span_count >= lim && span_count > 0) begin
      if (span_sleep[head_slot]) begin
        doze_total -= span_mem[head_slot];
      end else begin
        busy_total -= span_mem[head_slot];
      end
      head_slot = head_slot + 6'd1;
      span_count--;
    end
    slot = head_slot + span_count[5:0];
    span_mem[slot] = dur;
    span_sleep[slot] = is_sleep;
    if (is_sleep) begin
      doze_total += dur;
    end else begin
      busy_total += dur;
    end
    span_count++;
  endtask

  task automatic predict_load(input logic [REQ_W-1:0] req, input logic [STAMP_W-1:0] stamp);
    logic [STAMP_W-1:0] gap;
    logic [63:0]        s;
    logic [63:0]        r;
    logic [63:0]        tot;
    logic [LOAD_W-1:0]  pct;
    case (req)
      REQ_SLEEP: begin
        gap = stamp - wake_stamp;
        dozing = 1'b1;
        doze_stamp = stamp;
        log_interval(gap, 1'b0);
      end
      REQ_WORK: begin
        gap = stamp - doze_stamp;
        dozing = 1'b0;
        wake_stamp = stamp;
        log_interval(gap, 1'b1);
      end
      REQ_QUERY: begin
        s = doze_total;
        r = busy_total;
        pct = '0;
        if (span_count != 0) begin
          if (dozing) begin
            gap = stamp - doze_stamp;
            s += gap;
          end else begin
            gap = stamp - wake_stamp;
            r += gap;
          end
          tot = s + r;
          if (tot != 0) begin
            pct = LOAD_W'((r * PCT_MAX) / tot);
          end
        end
        load_expected.push_back(pct);
      end
      default: begin
      end
    endcase
  endtask

  task automatic push_item(input logic [REQ_W-1:0] req, input logic [STAMP_W-1:0] stamp);
    send_queue.push_back(meter_item_t'{req, stamp});
  endtask

  task automatic gen_phase(input int n);
    int               k;
    int unsigned      pick;
    logic [REQ_W-1:0] req;
    k = 0;
    while (k < n) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        req = REQ_BAD;
      end else if (pick < 38) begin
        req = REQ_QUERY;
      end else if (pick < 88) begin
        req = gen_asleep ? REQ_WORK : REQ_SLEEP;
      end else begin
        req = $urandom_range(1) ? REQ_WORK : REQ_SLEEP;
      end
      if (req == REQ_SLEEP) begin
        gen_asleep = 1'b1;
      end else if (req == REQ_WORK) begin
        gen_asleep = 1'b0;
      end
      pick = $urandom_range(99);
      if (pick < 5) begin
        gen_clock = $urandom;
      end else if (pick < 10) begin
        gen_clock = gen_clock;
      end else if (pick < 45) begin
        gen_clock += $urandom_range(1000);
      end else if (pick < 88) begin
        gen_clock += $urandom_range(32'd1 << 20);
      end else begin
        gen_clock += $urandom;
      end
      push_item(req, gen_clock);
      if (req != REQ_BAD) begin
        k++;
      end
    end
  endtask

  task automatic wait_drained();
    while (send_queue.size() != 0 || in_ch.valid || load_expected.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [WSIZE_W-1:0] value);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.window_size <= value;
    do begin
      @(posedge clk_i);
    end while (!cfg_ch.ready);
    size_reg = value;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    req_fire <= in_ch.valid && in_ch.ready;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      predict_load(in_ch.req_type, in_ch.now_usec);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_ch.valid || req_fire)) begin
      if (send_queue.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        next_item = send_queue[0];
        send_queue.delete(0);
        in_ch.valid <= 1'b1;
        in_ch.req_type <= next_item.req;
        in_ch.now_usec <= next_item.stamp;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_ch.ready <= rst_ni && (quiet || $urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (load_expected.size() == 0) begin
        report_mismatch($sformatf("load %0d with no result pending", out_ch.load_percent));
      end else begin
        want_load = load_expected[0];
        load_expected.delete(0);
        if (out_ch.load_percent !== want_load) begin
          report_mismatch($sformatf("load_percent got %0d, expected %0d",
                                    out_ch.load_percent, want_load));
        end
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_SLEEP;
    in_ch.now_usec = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.window_size = WSIZE_RESET;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    push_item(REQ_QUERY, 32'd0);
    push_item(REQ_BAD,   32'd5);
    push_item(REQ_SLEEP, 32'd0);
    push_item(REQ_QUERY, 32'd0);
    push_item(REQ_WORK,  32'd1000);
    push_item(REQ_QUERY, 32'd1000);
    push_item(REQ_SLEEP, 32'd4000);
    push_item(REQ_QUERY, 32'd4000);
    push_item(REQ_SLEEP, 32'd5000);
    push_item(REQ_WORK,  32'd5000);
    push_item(REQ_WORK,  32'd6000);
    push_item(REQ_QUERY, 32'd6000);
    push_item(REQ_SLEEP, 32'hFFFF_FF00);
    push_item(REQ_WORK,  32'h0000_0100);
    push_item(REQ_QUERY, 32'hFFFF_FFFF);
    push_item(REQ_BAD,   32'hFFFF_FFFF);
    push_item(REQ_SLEEP, 32'h8000_0000);
    push_item(REQ_QUERY, 32'h7FFF_FFFF);
    push_item(REQ_WORK,  32'h7FFF_FFFF);
    push_item(REQ_QUERY, 32'h7FFF_FFFF);
    push_item(REQ_SLEEP, 32'hFFFF_FFFF);
    push_item(REQ_QUERY, 32'h5555_5555);
    gen_clock = 32'h5555_5555;
    gen_asleep = 1'b1;
    wait_drained();

    foreach (size_plan[p]) begin
      write_window(size_plan[p]);
      gen_phase(PHASE_ITEMS);
      wait_drained();
    end
    write_window(WSIZE_W'($urandom_range(127)));
    gen_phase(PHASE_ITEMS);
    wait_drained();

    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/wbrm_pkg.sv
rtl/core/wbrm_req_if.sv
rtl/core/wbrm_rsp_if.sv
rtl/core/wbrm_cfg_if.sv
rtl/core/wbrm_ctrl.sv
rtl/core/wbrm_dp.sv
rtl/core/windowed_busy_ratio_meter_core.sv
verif/tb_windowed_busy_ratio_meter_core.sv
